/* design/kfd_pkg.sv */
// kfd_pkg: shared constants, codes and types for the KISS frame deframer.
// Used by kfd_decode and kiss_frame_deframer; depends on nothing.
`timescale 1ns / 1ps
package kfd_pkg;

    localparam int MAX_FRAME_BYTES = 512;
    localparam int FRAME_CNT_W     = $clog2(MAX_FRAME_BYTES + 1);
    localparam int LIMIT_W         = 10;
    localparam int COUNT_W         = 9;

    localparam logic [7:0] FEND_CODE  = 8'hC0;
    localparam logic [7:0] FESC_CODE  = 8'hDB;
    localparam logic [7:0] TFEND_CODE = 8'hDC;
    localparam logic [7:0] TFESC_CODE = 8'hDD;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_BADESC = 2'd2,
        KIND_LONG   = 2'd3
    } kind_t;

    typedef struct packed {
        logic                   frame_open;
        logic                   escape_pending;
        logic [FRAME_CNT_W-1:0] frame_count;
        logic [3:0]             port_held;
        logic [3:0]             command_held;
    } kfd_state_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         data_byte;
        logic [3:0]         port;
        logic [3:0]         command;
        logic [COUNT_W-1:0] count;
    } kfd_result_t;

endpackage

/* design/kfd_decode.sv */
// kfd_decode: combinational next-state and result logic for one received word.
// Depends on kfd_pkg.
`timescale 1ns / 1ps
module kfd_decode
    import kfd_pkg::*;
(
    input  kfd_state_t        cur_state,
    input  logic [7:0]        rx_byte,
    input  logic [LIMIT_W-1:0] frame_limit,
    output kfd_state_t        nxt_state,
    output logic              res_valid,
    output kfd_result_t       res
);

    logic [FRAME_CNT_W-1:0] eff_limit;
    logic [FRAME_CNT_W-1:0] cnt_m1;
    logic [7:0]             plain_byte;
    logic                   store_ok;

    always_comb begin
        if (frame_limit == '0) begin
            eff_limit = FRAME_CNT_W'(1);
        end else if (FRAME_CNT_W'(frame_limit) > FRAME_CNT_W'(MAX_FRAME_BYTES)) begin
            eff_limit = FRAME_CNT_W'(MAX_FRAME_BYTES);
        end else begin
            eff_limit = FRAME_CNT_W'(frame_limit);
        end
    end

    assign cnt_m1 = cur_state.frame_count - FRAME_CNT_W'(1);

    always_comb begin
        nxt_state  = cur_state;
        res_valid  = 1'b0;
        res        = '0;
        res.kind   = KIND_DATA;
        plain_byte = rx_byte;
        store_ok   = 1'b0;

        if (rx_byte == FEND_CODE) begin
            nxt_state.frame_open     = 1'b1;
            nxt_state.escape_pending = 1'b0;
            nxt_state.frame_count    = '0;
            if (cur_state.frame_open && cur_state.frame_count != '0) begin
                res_valid   = 1'b1;
                res.kind    = KIND_DONE;
                res.port    = cur_state.port_held;
                res.command = cur_state.command_held;
                res.count   = cnt_m1[COUNT_W-1:0];
            end
        end else if (cur_state.frame_open) begin
            if (cur_state.escape_pending) begin
                nxt_state.escape_pending = 1'b0;
                if (rx_byte == TFEND_CODE) begin
                    plain_byte = FEND_CODE;
                    store_ok   = 1'b1;
                end else if (rx_byte == TFESC_CODE) begin
                    plain_byte = FESC_CODE;
                    store_ok   = 1'b1;
                end else begin
                    nxt_state.frame_count = '0;
                    res_valid             = 1'b1;
                    res.kind              = KIND_BADESC;
                end
            end else if (rx_byte == FESC_CODE) begin
                nxt_state.escape_pending = 1'b1;
            end else begin
                store_ok = 1'b1;
            end

            if (store_ok) begin
                if (cur_state.frame_count >= eff_limit) begin
                    nxt_state.escape_pending = 1'b0;
                    nxt_state.frame_count    = '0;
                    res_valid                = 1'b1;
                    res.kind                 = KIND_LONG;
                end else if (cur_state.frame_count == '0) begin
                    nxt_state.port_held    = plain_byte[7:4];
                    nxt_state.command_held = plain_byte[3:0];
                    nxt_state.frame_count  = FRAME_CNT_W'(1);
                end else begin
                    nxt_state.frame_count = cur_state.frame_count + FRAME_CNT_W'(1);
                    res_valid             = 1'b1;
                    res.kind              = KIND_DATA;
                    res.data_byte         = plain_byte;
                    res.port              = cur_state.port_held;
                    res.command           = cur_state.command_held;
                    res.count             = cnt_m1[COUNT_W-1:0];
                end
            end
        end
    end

endmodule

/* design/kiss_frame_deframer.sv */
// kiss_frame_deframer: KISS receive deframer, top level.
// Depends on kfd_pkg and kfd_decode.
`timescale 1ns / 1ps
//
//  channel   ports                                   handshake
//  input     s_valid s_ready s_rx_byte               valid/ready
//  result    m_valid m_ready m_kind m_data_byte      valid/ready
//            m_port m_command m_count
//  config    cfg_we cfg_wdata (frame_limit)          write enable, no wait
//
// One word per cycle while the result is not stalled: a word goes input register -> decode ->
// result register, so the result is registered by those two register stages.
// Synchronous active-low reset clears frame state and sets frame_limit to 512;
// s_ready stays low while reset is held.
// A stalled result holds the result register; the input register holds at most
// one more word, then s_ready drops until the result is taken.
module kiss_frame_deframer
    import kfd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic [7:0]         m_data_byte,
    output logic [3:0]         m_port,
    output logic [3:0]         m_command,
    output logic [COUNT_W-1:0] m_count
);

    logic [LIMIT_W-1:0] limit_reg;
    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    kfd_state_t         state_reg;
    kfd_state_t         state_next;
    logic               res_valid;
    kfd_result_t        res;
    logic               out_valid_reg;
    kfd_result_t        out_reg;
    logic               advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = aresetn && (!in_valid_reg || advance);

    kfd_decode u_decode (
        .cur_state   (state_reg),
        .rx_byte     (in_byte_reg),
        .frame_limit (limit_reg),
        .nxt_state   (state_next),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_W'(MAX_FRAME_BYTES);
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res_valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_kind      = out_reg.kind;
    assign m_data_byte = out_reg.data_byte;
    assign m_port      = out_reg.port;
    assign m_command   = out_reg.command;
    assign m_count     = out_reg.count;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.frame_count <= FRAME_CNT_W'(MAX_FRAME_BYTES))
        else $error("frame count beyond maximum");

    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.frame_open |-> (state_reg.frame_count == '0 && !state_reg.escape_pending))
        else $error("frame state set outside a frame");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (out_reg.kind == KIND_BADESC || out_reg.kind == KIND_LONG))
        |-> (m_data_byte == '0 && m_count == '0 && m_port == '0 && m_command == '0))
        else $error("error result carries payload");

    a_stall_no_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(state_reg))
        else $error("frame state moved while result stalled");

endmodule
